/* hdl/madt_stream_parser_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the MADT stream parser unit
// Clocked on clk_i and quiet while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef MADT_STREAM_PARSER_UNIT_ASSERT_SVH
`define MADT_STREAM_PARSER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MADT_SP_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The condition must never be seen.
`define MADT_SP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

/* hdl/madt_sp_pkg.sv */
// ----------------------------------------------------------------------------
// MADT stream parser package
// Shared constants, word and result types of the MADT stream parser.
// ----------------------------------------------------------------------------
package madt_sp_pkg;

  localparam int unsigned MAX_PROCESSORS = 64;
  localparam int unsigned ID_IDX_W       = $clog2(MAX_PROCESSORS);
  localparam int unsigned CPU_CNT_W      = 7;

  localparam logic [63:0] DEFAULT_BASE = 64'h0000_0000_fee0_0000;
  localparam logic [7:0]  ID_NONE      = 8'hff;

  // Header layout.
  localparam logic [31:0] HEADER_END  = 32'd44;
  localparam logic [31:0] POS_LEN_LO  = 32'd4;
  localparam logic [31:0] POS_LEN_HI  = 32'd7;
  localparam logic [31:0] POS_BASE_LO = 32'd36;
  localparam logic [31:0] POS_BASE_HI = 32'd39;
  localparam logic [31:0] POS_FIRST_CHECK = 32'd8;

  // Entry layout.
  localparam logic [7:0] OFF_TYPE       = 8'd0;
  localparam logic [7:0] OFF_LEN        = 8'd1;
  localparam logic [7:0] OFF_APIC_ID    = 8'd3;
  localparam logic [7:0] OFF_FIELD_LO   = 8'd4;
  localparam logic [7:0] OFF_FLAGS_LAST = 8'd7;
  localparam logic [7:0] OFF_FIELD_HI   = 8'd11;
  localparam logic [7:0] ENTRY_MIN_LEN  = 8'd2;

  localparam logic [7:0] ENTRY_LAPIC         = 8'd0;
  localparam logic [7:0] ENTRY_ADDR_OVERRIDE = 8'd5;
  localparam logic [7:0] LAPIC_MIN_LEN       = 8'd8;
  localparam logic [7:0] OVERRIDE_MIN_LEN    = 8'd12;

  // Command and reply codes.
  localparam logic CMD_TABLE     = 1'b0;
  localparam logic CMD_READ      = 1'b1;
  localparam logic REPLY_SUMMARY = 1'b0;
  localparam logic REPLY_READ    = 1'b1;

  // Queue sizes.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned RFIFO_DEPTH = 4;
  localparam int unsigned RFIFO_PTR_W = $clog2(RFIFO_DEPTH);
  localparam int unsigned RFIFO_CNT_W = $clog2(RFIFO_DEPTH + 1);

  typedef struct packed {
    logic                is_read;
    logic                first;
    logic [7:0]          data;
    logic [ID_IDX_W-1:0] index;
  } word_t;

  typedef struct packed {
    logic                 kind;
    logic                 ok;
    logic [CPU_CNT_W-1:0] count;
    logic [63:0]          base;
    logic [7:0]           apic_id;
  } result_t;

  typedef struct packed {
    logic [RFIFO_CNT_W-1:0] count;
    logic                   full;
  } rfifo_status_t;

endpackage

/* hdl/madt_stream_parser_unit.sv */
// ----------------------------------------------------------------------------
// MADT stream parser unit
// Parses an ACPI MADT table a byte per word and answers APIC id reads.
// ----------------------------------------------------------------------------
// Usage:
// The input side is a queue: a word is taken at a clock edge where push is
// high and full is low. A word is either a table byte (command 0, with
// first_byte marking the start of a new table) or a read of the stored APIC
// id at cpu_index (command 1).
// The result side is a queue as well: while empty is low the oldest result
// word is on the result ports, and it leaves at an edge where pop is high.
// Only the last byte of a table and every read produce a result word.
// Throughput is one word per cycle while the result queue has room. A word
// passes the front queue and the back end's reply stage before its result
// word is on the result ports, where it can be popped.
// Reads and summaries take the same path; the registered id store read lines
// up with the reply stage.
// When the reader stalls, the result queue (four words) fills, the back end
// holds and then the front queue (two words) raises full.
// Reset empties both queues, restarts the parse at byte 0, sets the count to
// zero and the base to 0xfee00000. The id store is not cleared.
// ----------------------------------------------------------------------------
`include "madt_stream_parser_unit_assert.svh"

module madt_stream_parser_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic                              command_i,
  input  logic [7:0]                        table_byte_i,
  input  logic                              first_byte_i,
  input  logic [madt_sp_pkg::ID_IDX_W-1:0]  cpu_index_i,
  output logic                              empty,
  input  logic                              pop,
  output logic                              reply_kind_o,
  output logic                              checksum_ok_o,
  output logic [madt_sp_pkg::CPU_CNT_W-1:0] cpu_count_o,
  output logic [63:0]                       lapic_base_o,
  output logic [7:0]                        apic_id_o
);

  // Front to back: classified words.
  logic                       word_valid, word_take;
  madt_sp_pkg::word_t         word;

  // Back to result queue.
  logic                       res_valid;
  madt_sp_pkg::result_t       res, res_out;
  madt_sp_pkg::rfifo_status_t rf_status;

  // What the result ports currently show, for the checks below.
  logic                       summary_shown, read_shown, fail_shown, summary_sane;

  madt_sp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .command_i   (command_i),
    .table_byte_i(table_byte_i),
    .first_byte_i(first_byte_i),
    .cpu_index_i (cpu_index_i),
    .word_valid_o(word_valid),
    .word_o      (word),
    .word_take_i (word_take)
  );

  // The back end runs a word only when its reply is sure to find room.
  madt_sp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .word_valid_i(word_valid),
    .word_i      (word),
    .word_take_o (word_take),
    .rf_status_i (rf_status),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  madt_sp_rfifo u_rfifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (res_out),
    .status_o(rf_status)
  );

  assign reply_kind_o  = res_out.kind;
  assign checksum_ok_o = res_out.ok;
  assign cpu_count_o   = res_out.count;
  assign lapic_base_o  = res_out.base;
  assign apic_id_o     = res_out.apic_id;

  assign summary_shown = !empty && (reply_kind_o == madt_sp_pkg::REPLY_SUMMARY);
  assign read_shown    = !empty && (reply_kind_o == madt_sp_pkg::REPLY_READ);
  assign fail_shown    = summary_shown && !checksum_ok_o;
  assign summary_sane  = (apic_id_o == 8'd0) &&
                         (cpu_count_o <= madt_sp_pkg::CPU_CNT_W'(madt_sp_pkg::MAX_PROCESSORS));

  // The reservation in the back end must keep the result queue from overflowing.
  `MADT_SP_ASSERT_NEVER(a_rfifo_no_overflow, res_valid && rf_status.full, "result queue overflow")

  // A failed table never commits a processor count.
  `MADT_SP_ASSERT_IMPLIES(a_fail_clears_count, fail_shown, cpu_count_o == '0, "failed count")

  // Read replies never claim a checksum result and summaries carry no id.
  `MADT_SP_ASSERT_IMPLIES(a_read_no_ok, read_shown, !checksum_ok_o, "read reply with ok flag")
  `MADT_SP_ASSERT_IMPLIES(a_summary_no_id, summary_shown, summary_sane, "bad summary fields")

endmodule

/* hdl/madt_sp_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module madt_sp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/madt_sp_front.sv */
// ----------------------------------------------------------------------------
// MADT parser front end
// Accepts words, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module madt_sp_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  output logic                             full_o,
  input  logic                             command_i,
  input  logic [7:0]                       table_byte_i,
  input  logic                             first_byte_i,
  input  logic [madt_sp_pkg::ID_IDX_W-1:0] cpu_index_i,
  output logic                             word_valid_o,
  output madt_sp_pkg::word_t               word_o,
  input  logic                             word_take_i
);

  madt_sp_pkg::word_t                        queue_q [madt_sp_pkg::QUEUE_DEPTH];
  madt_sp_pkg::word_t                        word_in;
  logic [madt_sp_pkg::QUEUE_PTR_W-1:0]       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [madt_sp_pkg::QUEUE_CNT_W-1:0]       count_q, count_d;
  logic                                      push_ok, take;

  // A read command ignores the restart flag.
  always_comb begin
    word_in.is_read = (command_i == madt_sp_pkg::CMD_READ);
    word_in.first   = first_byte_i && (command_i == madt_sp_pkg::CMD_TABLE);
    word_in.data    = table_byte_i;
    word_in.index   = cpu_index_i;
  end

  assign full_o       = (count_q == madt_sp_pkg::QUEUE_CNT_W'(madt_sp_pkg::QUEUE_DEPTH));
  assign push_ok      = push_i && !full_o;
  assign word_valid_o = (count_q != '0);
  assign take         = word_take_i && word_valid_o;
  assign word_o       = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_ok) begin
      wr_ptr_d = (wr_ptr_q == madt_sp_pkg::QUEUE_PTR_W'(madt_sp_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (take) begin
      rd_ptr_d = (rd_ptr_q == madt_sp_pkg::QUEUE_PTR_W'(madt_sp_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (push_ok && !take) begin
      count_d = count_q + 1'b1;
    end else if (take && !push_ok) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      queue_q[wr_ptr_q] <= word_in;
    end
  end

endmodule

/* hdl/madt_sp_back.sv */
// ----------------------------------------------------------------------------
// MADT parser back end
// Walks a table a byte a cycle unless held, keeps the APIC ids, builds replies.
// ----------------------------------------------------------------------------
module madt_sp_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       word_valid_i,
  input  madt_sp_pkg::word_t         word_i,
  output logic                       word_take_o,
  input  madt_sp_pkg::rfifo_status_t rf_status_i,
  output logic                       res_valid_o,
  output madt_sp_pkg::result_t       res_o
);

  localparam int unsigned CW  = madt_sp_pkg::CPU_CNT_W;
  localparam int unsigned SW  = madt_sp_pkg::RFIFO_CNT_W + 1;

  // Parser state.
  logic [31:0]   pos_q, pos_d, len_q, len_d;
  logic [7:0]    sum_q, sum_d, off_q, off_d;
  logic [7:0]    etype_q, etype_d, elen_q, elen_d, eid_q, eid_d;
  logic [63:0]   fs_q, fs_d, pbase_q, pbase_d, cbase_q, cbase_d;
  logic          stop_q, stop_d;
  logic [CW-1:0] pcount_q, pcount_d, ccount_q, ccount_d;

  // Reply stage that waits for the registered store read data.
  logic          s2_valid_q, s2_valid_d;
  logic          s2_kind_q, s2_ok_q, s2_hit_q;
  logic [CW-1:0] s2_count_q;
  logic [63:0]   s2_base_q;

  logic          go, exec_byte;
  logic [31:0]   pos;
  logic          restart, walk, blocked, done, ok;
  logic          wr_en;
  logic [madt_sp_pkg::ID_IDX_W-1:0] wr_addr;
  logic [7:0]    wr_data, ram_rdata;
  logic          hit;
  logic [2:0]    lane;

  // An item only runs when its reply is sure of a place in the result queue.
  assign go = word_valid_i &&
              ((SW'(rf_status_i.count) + SW'(s2_valid_q)) < SW'(madt_sp_pkg::RFIFO_DEPTH));
  assign word_take_o = go;
  assign exec_byte   = go && !word_i.is_read;
  assign hit = ({1'b0, word_i.index} < ccount_q);

  always_comb begin
    pos     = word_i.first ? '0 : pos_q;
    restart = (pos == '0);
    sum_d   = (restart ? 8'd0 : sum_q) + word_i.data;
    len_d   = restart ? '0 : len_q;
    fs_d    = restart ? '0 : fs_q;
    stop_d  = restart ? 1'b0 : stop_q;
    off_d   = restart ? '0 : off_q;
    pcount_d = restart ? '0 : pcount_q;
    pbase_d = restart ? madt_sp_pkg::DEFAULT_BASE : pbase_q;
    etype_d = etype_q;
    elen_d  = elen_q;
    eid_d   = eid_q;
    wr_en   = 1'b0;
    wr_addr = pcount_d[madt_sp_pkg::ID_IDX_W-1:0];
    wr_data = eid_q;
    blocked = 1'b0;
    lane    = 3'(off_d - madt_sp_pkg::OFF_FIELD_LO);

    // Header: table length and local APIC base.
    if (pos >= madt_sp_pkg::POS_LEN_LO && pos <= madt_sp_pkg::POS_LEN_HI) begin
      len_d[8*pos[1:0] +: 8] = word_i.data;
    end
    if (pos >= madt_sp_pkg::POS_BASE_LO && pos <= madt_sp_pkg::POS_BASE_HI) begin
      if (pos == madt_sp_pkg::POS_BASE_LO) begin
        fs_d = '0;
      end
      fs_d[8*pos[1:0] +: 8] = fs_d[8*pos[1:0] +: 8] | word_i.data;
      if (pos == madt_sp_pkg::POS_BASE_HI) begin
        pbase_d = fs_d;
      end
    end

    // Entry walk.
    walk = (pos >= madt_sp_pkg::HEADER_END) && !stop_d && (pos < len_d);
    if (walk) begin
      case (off_d)
        madt_sp_pkg::OFF_TYPE: begin
          if (({1'b0, pos} + 33'd2) > {1'b0, len_d}) begin
            blocked = 1'b1;
          end else begin
            etype_d = word_i.data;
            fs_d    = '0;
          end
        end
        madt_sp_pkg::OFF_LEN: begin
          if (word_i.data < madt_sp_pkg::ENTRY_MIN_LEN ||
              ({1'b0, pos - 32'd1} + 33'(word_i.data)) > {1'b0, len_d}) begin
            blocked = 1'b1;
          end else begin
            elen_d = word_i.data;
          end
        end
        default: begin
          if (off_d == madt_sp_pkg::OFF_APIC_ID) begin
            eid_d = word_i.data;
          end
          if (off_d >= madt_sp_pkg::OFF_FIELD_LO && off_d <= madt_sp_pkg::OFF_FIELD_HI) begin
            fs_d[8*lane +: 8] = fs_d[8*lane +: 8] | word_i.data;
          end
          if (etype_d == madt_sp_pkg::ENTRY_LAPIC && elen_d >= madt_sp_pkg::LAPIC_MIN_LEN &&
              off_d == madt_sp_pkg::OFF_FLAGS_LAST && fs_d[0] &&
              pcount_d < CW'(madt_sp_pkg::MAX_PROCESSORS)) begin
            wr_en    = 1'b1;
            wr_data  = eid_d;
            pcount_d = pcount_d + 1'b1;
          end
          if (etype_d == madt_sp_pkg::ENTRY_ADDR_OVERRIDE &&
              elen_d >= madt_sp_pkg::OVERRIDE_MIN_LEN &&
              off_d == madt_sp_pkg::OFF_FIELD_HI) begin
            pbase_d = fs_d;
          end
        end
      endcase
      if (blocked) begin
        stop_d = 1'b1;
      end else if (off_d != madt_sp_pkg::OFF_TYPE &&
                   ({1'b0, off_d} + 9'd1) >= {1'b0, elen_d}) begin
        off_d = '0;
      end else begin
        off_d = off_d + 8'd1;
      end
    end

    // End of table and commit.
    done = ((pos == madt_sp_pkg::POS_LEN_HI) && (len_d < madt_sp_pkg::HEADER_END)) ||
           ((pos >= madt_sp_pkg::POS_FIRST_CHECK) && (len_d >= madt_sp_pkg::HEADER_END) &&
            (pos == len_d - 32'd1));
    ok    = done && (pos != madt_sp_pkg::POS_LEN_HI) && (sum_d == 8'd0);
    pos_d = done ? '0 : pos + 32'd1;
    ccount_d = ccount_q;
    cbase_d  = cbase_q;
    if (done) begin
      ccount_d = ok ? pcount_d : '0;
      cbase_d  = ok ? pbase_d : cbase_q;
    end
  end

  assign s2_valid_d = go && (word_i.is_read || done);

  madt_sp_ram #(
    .WIDTH(8),
    .DEPTH(madt_sp_pkg::MAX_PROCESSORS)
  ) u_id_store (
    .clk_i  (clk_i),
    .we_i   (exec_byte && wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .raddr_i(word_i.index),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      len_q      <= '0;
      sum_q      <= '0;
      off_q      <= '0;
      etype_q    <= '0;
      elen_q     <= '0;
      eid_q      <= '0;
      fs_q       <= '0;
      stop_q     <= 1'b0;
      pcount_q   <= '0;
      pbase_q    <= madt_sp_pkg::DEFAULT_BASE;
      ccount_q   <= '0;
      cbase_q    <= madt_sp_pkg::DEFAULT_BASE;
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s2_valid_d;
      if (exec_byte) begin
        pos_q    <= pos_d;
        len_q    <= len_d;
        sum_q    <= sum_d;
        off_q    <= off_d;
        etype_q  <= etype_d;
        elen_q   <= elen_d;
        eid_q    <= eid_d;
        fs_q     <= fs_d;
        stop_q   <= stop_d;
        pcount_q <= pcount_d;
        pbase_q  <= pbase_d;
        ccount_q <= ccount_d;
        cbase_q  <= cbase_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      s2_kind_q  <= word_i.is_read ? madt_sp_pkg::REPLY_READ : madt_sp_pkg::REPLY_SUMMARY;
      s2_ok_q    <= !word_i.is_read && ok;
      s2_hit_q   <= hit;
      s2_count_q <= word_i.is_read ? ccount_q : ccount_d;
      s2_base_q  <= word_i.is_read ? cbase_q : cbase_d;
    end
  end

  always_comb begin
    res_o.kind  = s2_kind_q;
    res_o.ok    = s2_ok_q;
    res_o.count = s2_count_q;
    res_o.base  = s2_base_q;
    if (s2_kind_q == madt_sp_pkg::REPLY_READ) begin
      res_o.apic_id = s2_hit_q ? ram_rdata : madt_sp_pkg::ID_NONE;
    end else begin
      res_o.apic_id = 8'd0;
    end
  end

  assign res_valid_o = s2_valid_q;

endmodule

/* hdl/madt_sp_rfifo.sv */
// ----------------------------------------------------------------------------
// MADT parser result queue
// Small register queue that decouples the back end from the result reader.
// ----------------------------------------------------------------------------
module madt_sp_rfifo (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  madt_sp_pkg::result_t       data_i,
  input  logic                       pop_i,
  output logic                       empty_o,
  output madt_sp_pkg::result_t       data_o,
  output madt_sp_pkg::rfifo_status_t status_o
);

  localparam int unsigned PW = madt_sp_pkg::RFIFO_PTR_W;
  localparam int unsigned CW = madt_sp_pkg::RFIFO_CNT_W;

  madt_sp_pkg::result_t mem_q [madt_sp_pkg::RFIFO_DEPTH];
  logic [PW-1:0]        wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]        count_q, count_d;
  logic                 take;

  assign empty_o = (count_q == '0);
  assign take    = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];
  assign status_o.count = count_q;
  assign status_o.full  = (count_q == CW'(madt_sp_pkg::RFIFO_DEPTH));

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(madt_sp_pkg::RFIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (take) begin
      rd_ptr_d = (rd_ptr_q == PW'(madt_sp_pkg::RFIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !take) begin
      count_d = count_q + 1'b1;
    end else if (take && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
